/* sv/rffq_pkg.sv */
// Shared widths, register indexes, limits and control types for the restoring force unit.
package rffq_pkg;

    localparam int Q_W        = 16;
    localparam int MASS_W     = 24;
    localparam int POS_W      = 16;
    localparam int FORCE_W    = 26;
    localparam int MOMENT_W   = 30;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam int PROD_W     = 2 * Q_W;
    localparam int D_W        = 34;
    localparam int SMASS_W    = MASS_W + 1;
    localparam int SPLIT_W    = 17;
    localparam int FMUL_W     = SMASS_W + D_W;
    localparam int FRND_W     = FMUL_W - 30;
    localparam int FG_W       = 35;
    localparam int MMUL_W     = POS_W + FG_W;
    localparam int MSUM_W     = MMUL_W + 2;
    localparam int MRND_W     = MSUM_W - 20;
    localparam int STAGES     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUOYANCY = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COG_X    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COG_Y    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COG_Z    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COB_X    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COB_Y    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COB_Z    = 4'd7;

    localparam logic signed [D_W-1:0]      D_ONE      = 34'sd1073741824;
    localparam logic signed [FORCE_W-1:0]  FORCE_MAX  = 26'sh1000000;
    localparam logic signed [FORCE_W-1:0]  FORCE_MIN  = 26'sh3000000;
    localparam logic signed [MOMENT_W-1:0] MOMENT_MAX = {1'b0, {(MOMENT_W-1){1'b1}}};
    localparam logic signed [MOMENT_W-1:0] MOMENT_MIN = {1'b1, {(MOMENT_W-1){1'b0}}};

    typedef struct packed {
        logic ld_part;
        logic ld_prod;
    } mul_ctl_t;

endpackage

/* sv/rffq_split_mul.sv */
// Two-stage signed multiplier: split partial products, then recombined product.
module rffq_split_mul #(
    parameter int A_W  = 25,
    parameter int B_W  = 34,
    parameter int LO_W = 17
) (
    input  logic                        clk,
    input  rffq_pkg::mul_ctl_t          ctl,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);

    localparam int HI_W = B_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic signed [HI_W-1:0]       b_hi;
    logic signed [LO_W:0]         b_lo;
    logic signed [A_W+HI_W-1:0]   hi_reg;
    logic signed [A_W+LO_W:0]     lo_reg;
    logic signed [P_W-1:0]        p_next;
    logic signed [P_W-1:0]        p_reg;

    assign b_hi = b[B_W-1:LO_W];
    assign b_lo = $signed({1'b0, b[LO_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (ctl.ld_part)
        begin
            hi_reg <= a * b_hi;
            lo_reg <= a * b_lo;
        end
    end

    assign p_next = ($signed(P_W'(hi_reg)) <<< LO_W) + $signed(P_W'(lo_reg));

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* sv/restoring_force_from_quaternion_unit.sv */
// Top level: hydrostatic restoring forces and moments from an attitude quaternion.
//
// Takes one unit quaternion (Q1.15) per request and returns the body-frame restoring
// force (1/256 N) and moment (1/256 N m), both saturated. Fully pipelined: a request
// can be accepted every cycle unless an output stall has backed up to the first
// stage. The depth comes from the quaternion products, the down vector, two split
// multiplier stages for the weight and buoyancy products, a rounding stage, two split
// multiplier stages for the lever-arm cross products, the moment sum and the final
// round/saturate register. Stalls back up stage by stage and empty stages are filled,
// so bubbles do not hold up the input. Configuration writes are always ready and take
// effect at once; write them only with the pipeline empty.
module restoring_force_from_quaternion_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rffq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rffq_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [rffq_pkg::Q_W-1:0]        quat_w,
    input  logic signed [rffq_pkg::Q_W-1:0]        quat_x,
    input  logic signed [rffq_pkg::Q_W-1:0]        quat_y,
    input  logic signed [rffq_pkg::Q_W-1:0]        quat_z,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [rffq_pkg::FORCE_W-1:0]    force_x,
    output logic signed [rffq_pkg::FORCE_W-1:0]    force_y,
    output logic signed [rffq_pkg::FORCE_W-1:0]    force_z,
    output logic signed [rffq_pkg::MOMENT_W-1:0]   moment_x,
    output logic signed [rffq_pkg::MOMENT_W-1:0]   moment_y,
    output logic signed [rffq_pkg::MOMENT_W-1:0]   moment_z
);

    import rffq_pkg::*;

    // configuration
    logic [MASS_W-1:0]        weight_reg;
    logic [MASS_W-1:0]        buoyancy_reg;
    logic signed [POS_W-1:0]  cog_reg [3];
    logic signed [POS_W-1:0]  cob_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg   <= '0;
            buoyancy_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cog_reg[i] <= '0;
                cob_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WEIGHT:   weight_reg   <= cfg_data[MASS_W-1:0];
                REG_BUOYANCY: buoyancy_reg <= cfg_data[MASS_W-1:0];
                REG_COG_X:    cog_reg[0]   <= $signed(cfg_data[POS_W-1:0]);
                REG_COG_Y:    cog_reg[1]   <= $signed(cfg_data[POS_W-1:0]);
                REG_COG_Z:    cog_reg[2]   <= $signed(cfg_data[POS_W-1:0]);
                REG_COB_X:    cob_reg[0]   <= $signed(cfg_data[POS_W-1:0]);
                REG_COB_Y:    cob_reg[1]   <= $signed(cfg_data[POS_W-1:0]);
                REG_COB_Z:    cob_reg[2]   <= $signed(cfg_data[POS_W-1:0]);
                default:      ;
            endcase
        end
    end

    // pipeline control
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES:0]   ld;

    always_comb
    begin
        ld[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (!ld[k])
                v_next[k] = v_reg[k];
            else if (k == 0)
                v_next[k] = in_valid;
            else
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = v_reg[STAGES-1];

    // stage 0: quaternion products
    logic signed [PROD_W-1:0] xz_reg, wy_reg, yz_reg, wx_reg, xx_reg, yy_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            xz_reg <= quat_x * quat_z;
            wy_reg <= quat_w * quat_y;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
        end
    end

    // stage 1: body-frame down vector, units of 2^-30
    logic signed [D_W-1:0] d_reg [3];

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            d_reg[0] <= ($signed(D_W'(xz_reg)) - $signed(D_W'(wy_reg))) <<< 1;
            d_reg[1] <= ($signed(D_W'(yz_reg)) + $signed(D_W'(wx_reg))) <<< 1;
            d_reg[2] <= D_ONE - (($signed(D_W'(xx_reg)) + $signed(D_W'(yy_reg))) <<< 1);
        end
    end

    // stages 2-3: mass products
    logic signed [SMASS_W-1:0] net_mass;
    logic signed [SMASS_W-1:0] w_s;
    logic signed [SMASS_W-1:0] b_s;
    mul_ctl_t                  fmul_ctl;
    mul_ctl_t                  mmul_ctl;
    logic signed [FMUL_W-1:0]  fprod [3];
    logic signed [FMUL_W-1:0]  gprod [3];
    logic signed [FMUL_W-1:0]  bprod [3];

    assign w_s      = $signed({1'b0, weight_reg});
    assign b_s      = $signed({1'b0, buoyancy_reg});
    assign net_mass = w_s - b_s;
    assign fmul_ctl = '{ld_part: ld[2], ld_prod: ld[3]};
    assign mmul_ctl = '{ld_part: ld[5], ld_prod: ld[6]};

    // stage 4: rounding; stage 5: force clamp
    logic signed [FMUL_W-1:0]  ftmp [3];
    logic signed [FMUL_W-1:0]  gtmp [3];
    logic signed [FMUL_W-1:0]  btmp [3];
    logic signed [FRND_W-1:0]  frnd_reg [3];
    logic signed [FG_W-1:0]    fg_reg [3];
    logic signed [FG_W-1:0]    fb_reg [3];
    logic signed [FORCE_W-1:0] fsat_reg [3];
    logic signed [FORCE_W-1:0] fd6_reg [3];
    logic signed [FORCE_W-1:0] fd7_reg [3];
    logic signed [FORCE_W-1:0] fout_reg [3];

    // stages 5-8: moments
    logic signed [MMUL_W-1:0]   mp [3][4];
    logic signed [MSUM_W-1:0]   msum_reg [3];
    logic signed [MSUM_W-1:0]   mtmp [3];
    logic signed [MRND_W-1:0]   mrnd [3];
    logic signed [MOMENT_W-1:0] mout_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        rffq_split_mul #(.A_W(SMASS_W), .B_W(D_W), .LO_W(SPLIT_W)) u_fmul (
            .clk (clk), .ctl (fmul_ctl), .a (net_mass), .b (d_reg[i]), .p (fprod[i])
        );
        rffq_split_mul #(.A_W(SMASS_W), .B_W(D_W), .LO_W(SPLIT_W)) u_gmul (
            .clk (clk), .ctl (fmul_ctl), .a (w_s), .b (d_reg[i]), .p (gprod[i])
        );
        rffq_split_mul #(.A_W(SMASS_W), .B_W(D_W), .LO_W(SPLIT_W)) u_bmul (
            .clk (clk), .ctl (fmul_ctl), .a (b_s), .b (d_reg[i]), .p (bprod[i])
        );

        assign ftmp[i] = fprod[i] + $signed(FMUL_W'(1) << 29);
        assign gtmp[i] = gprod[i] + $signed(FMUL_W'(1) << 21);
        assign btmp[i] = bprod[i] + $signed(FMUL_W'(1) << 21);

        always_ff @(posedge clk)
        begin
            if (ld[4])
            begin
                frnd_reg[i] <= $signed(ftmp[i][FMUL_W-1:30]);
                fg_reg[i]   <= $signed(gtmp[i][22+FG_W-1:22]);
                fb_reg[i]   <= $signed(btmp[i][22+FG_W-1:22]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[5])
            begin
                priority if (frnd_reg[i] > $signed(FRND_W'(FORCE_MAX)))
                    fsat_reg[i] <= FORCE_MAX;
                else if (frnd_reg[i] < $signed(FRND_W'(FORCE_MIN)))
                    fsat_reg[i] <= FORCE_MIN;
                else
                    fsat_reg[i] <= frnd_reg[i][FORCE_W-1:0];
            end
            if (ld[6])
                fd6_reg[i] <= fsat_reg[i];
            if (ld[7])
                fd7_reg[i] <= fd6_reg[i];
            if (ld[8])
                fout_reg[i] <= fd7_reg[i];
        end

        rffq_split_mul #(.A_W(POS_W), .B_W(FG_W), .LO_W(SPLIT_W)) u_m0 (
            .clk (clk), .ctl (mmul_ctl), .a (cog_reg[J]), .b (fg_reg[K]), .p (mp[i][0])
        );
        rffq_split_mul #(.A_W(POS_W), .B_W(FG_W), .LO_W(SPLIT_W)) u_m1 (
            .clk (clk), .ctl (mmul_ctl), .a (cog_reg[K]), .b (fg_reg[J]), .p (mp[i][1])
        );
        rffq_split_mul #(.A_W(POS_W), .B_W(FG_W), .LO_W(SPLIT_W)) u_m2 (
            .clk (clk), .ctl (mmul_ctl), .a (cob_reg[J]), .b (fb_reg[K]), .p (mp[i][2])
        );
        rffq_split_mul #(.A_W(POS_W), .B_W(FG_W), .LO_W(SPLIT_W)) u_m3 (
            .clk (clk), .ctl (mmul_ctl), .a (cob_reg[K]), .b (fb_reg[J]), .p (mp[i][3])
        );

        always_ff @(posedge clk)
        begin
            if (ld[7])
            begin
                msum_reg[i] <= $signed(MSUM_W'(mp[i][0])) - $signed(MSUM_W'(mp[i][1]))
                             - $signed(MSUM_W'(mp[i][2])) + $signed(MSUM_W'(mp[i][3]));
            end
        end

        assign mtmp[i] = msum_reg[i] + $signed(MSUM_W'(1) << 19);
        assign mrnd[i] = $signed(mtmp[i][MSUM_W-1:20]);

        always_ff @(posedge clk)
        begin
            if (ld[8])
            begin
                priority if (mrnd[i] > $signed(MRND_W'(MOMENT_MAX)))
                    mout_reg[i] <= MOMENT_MAX;
                else if (mrnd[i] < $signed(MRND_W'(MOMENT_MIN)))
                    mout_reg[i] <= MOMENT_MIN;
                else
                    mout_reg[i] <= mrnd[i][MOMENT_W-1:0];
            end
        end
    end

    assign force_x  = fout_reg[0];
    assign force_y  = fout_reg[1];
    assign force_z  = fout_reg[2];
    assign moment_x = mout_reg[0];
    assign moment_y = mout_reg[1];
    assign moment_z = mout_reg[2];

    // checks
    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[0])
        else $error("accepted request not captured in first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !v_reg[STAGES-2] |=> !out_valid)
        else $error("result repeated after being taken");

    a_force_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> force_x <= FORCE_MAX && force_x >= FORCE_MIN
                   && force_y <= FORCE_MAX && force_y >= FORCE_MIN
                   && force_z <= FORCE_MAX && force_z >= FORCE_MIN)
        else $error("force outside saturation range");

endmodule
